FILE: hdl/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

    localparam int unsigned SIDE    = 5;
    localparam int unsigned CELLS   = SIDE * SIDE;
    localparam int unsigned LETTERS = 26;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LETTER_I = 5'd8;
    localparam letter_t LETTER_J = 5'd9;
    localparam letter_t LETTER_X = 5'd23;
    localparam letter_t LETTER_Z = 5'd25;
    localparam letter_t LAST_LETTER = 5'(LETTERS - 1);
    localparam cell_t   NUM_CELLS   = 5'(CELLS);

    typedef enum logic [1:0] {
        OP_KEY     = 2'd0,
        OP_KEY_END = 2'd1,
        OP_TEXT    = 2'd2,
        OP_END     = 2'd3
    } op_t;

    // Source of the second letter of a pair.
    typedef enum logic [1:0] {
        B_INPUT,
        B_X,
        B_Z
    } bsel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_POS_A,
        ST_POS_B,
        ST_EMIT_A,
        ST_EMIT_B
    } ctrl_state_t;

    typedef struct packed {
        logic  capture;
        logic  place_input;
        logic  fill_start;
        logic  fill_step;
        logic  pair_load;
        bsel_t b_sel;
        logic  held_set;
        logic  held_clear;
        logic  pos_a;
        logic  pos_b;
        logic  emit_a;
        logic  emit_b;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic is_letter;
        logic held_valid;
        logic held_match;
        logic fill_done;
        logic out_free;
    } status_t;

    function automatic coord_t row_of(input cell_t c);
        coord_t r;
        if (c >= 5'd20) begin
            r = 3'd4;
        end else if (c >= 5'd15) begin
            r = 3'd3;
        end else if (c >= 5'd10) begin
            r = 3'd2;
        end else if (c >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic coord_t col_of(input cell_t c);
        coord_t r;
        cell_t  base;
        r    = row_of(c);
        base = cell_t'({2'b00, r} << 2) + cell_t'({2'b00, r});
        return coord_t'(c - base);
    endfunction

    function automatic cell_t cell_at(input coord_t r, input coord_t c);
        return cell_t'({2'b00, r} << 2) + cell_t'({2'b00, r}) + cell_t'({2'b00, c});
    endfunction

    function automatic coord_t next_mod5(input coord_t v);
        return (v == 3'd4) ? 3'd0 : coord_t'(v + 3'd1);
    endfunction

    // Returns {is_letter, index}; the index is zero for a non-letter.
    function automatic logic [5:0] ascii_index(input logic [7:0] b);
        logic [5:0] r;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = {1'b1, 5'(b - 8'h61)};
        end else if (b >= 8'h41 && b <= 8'h5A) begin
            r = {1'b1, 5'(b - 8'h41)};
        end else begin
            r = 6'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/playfair_encryptor_core.sv
`default_nettype none

// Channel  Ports                                  Moves
// s_       s_valid s_ready s_op s_letter          one request: key byte, key end, text, end
// m_       m_valid m_ready m_cipher_letter m_last one cipher letter, m_last on the second
//
// One request at a time. Key bytes, non-letters and single text letters go from idle through decode and back.
// Key end also runs the fill, which walks all 26 letters, one per cycle.
// A text pair takes two cell lookups, then two square reads that wait for a free output register.
// The output register lets the next request in while the last letter waits.
// Synchronous reset clears the key square, the position table and any open pair.

module playfair_encryptor_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [7:0]  s_letter,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_cipher_letter,
    output logic             m_last
);

    pfe_pkg::cmd_t    cmd;
    pfe_pkg::status_t status;

    pfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pfe_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_op            (s_op),
        .s_letter        (s_letter),
        .m_ready         (m_ready),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_cipher_letter (m_cipher_letter),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

FILE: hdl/pfe_datapath.sv
`default_nettype none

module pfe_datapath (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [1:0]      s_op,
    input  wire logic [7:0]      s_letter,
    input  wire logic            m_ready,
    input  wire pfe_pkg::cmd_t   cmd,
    output pfe_pkg::status_t     status,
    output logic                 m_valid,
    output logic [4:0]           m_cipher_letter,
    output logic                 m_last
);

    pfe_pkg::op_t     op_reg;
    pfe_pkg::letter_t idx_reg;
    logic             is_letter_reg;

    pfe_pkg::letter_t key_square_reg [pfe_pkg::CELLS];
    pfe_pkg::cell_t   position_reg   [pfe_pkg::LETTERS];
    logic [pfe_pkg::LETTERS-1:0] used_reg;
    pfe_pkg::cell_t   fill_count_reg;
    pfe_pkg::letter_t held_letter_reg;
    logic             held_valid_reg;
    pfe_pkg::letter_t walk_reg;

    pfe_pkg::letter_t a_reg;
    pfe_pkg::letter_t b_reg;
    pfe_pkg::cell_t   pa_reg;
    pfe_pkg::cell_t   pb_reg;

    logic             m_valid_reg;
    pfe_pkg::letter_t m_letter_reg;
    logic             m_last_reg;

    logic [5:0]       in_decoded;
    pfe_pkg::letter_t place_idx;
    logic             place_ok;
    pfe_pkg::letter_t lookup_idx;
    pfe_pkg::cell_t   lookup_cell;
    pfe_pkg::coord_t  r1, c1, r2, c2;
    pfe_pkg::cell_t   oa, ob, emit_addr;
    logic             out_free;

    assign in_decoded = pfe_pkg::ascii_index(s_letter);

    assign place_idx = cmd.fill_step ? walk_reg : idx_reg;
    assign place_ok  = (cmd.place_input || cmd.fill_step)
                       && (fill_count_reg < pfe_pkg::NUM_CELLS)
                       && !used_reg[place_idx];

    // i and j share a cell, so j is looked up as i.
    always_comb begin
        lookup_idx = cmd.pos_b ? b_reg : a_reg;
        if (lookup_idx == pfe_pkg::LETTER_J) begin
            lookup_idx = pfe_pkg::LETTER_I;
        end
    end
    assign lookup_cell = position_reg[lookup_idx];

    assign r1 = pfe_pkg::row_of(pa_reg);
    assign c1 = pfe_pkg::col_of(pa_reg);
    assign r2 = pfe_pkg::row_of(pb_reg);
    assign c2 = pfe_pkg::col_of(pb_reg);

    // A pair in one cell falls under the same-row rule, as it should.
    always_comb begin
        if (r1 == r2) begin
            oa = pfe_pkg::cell_at(r1, pfe_pkg::next_mod5(c1));
            ob = pfe_pkg::cell_at(r2, pfe_pkg::next_mod5(c2));
        end else if (c1 == c2) begin
            oa = pfe_pkg::cell_at(pfe_pkg::next_mod5(r1), c1);
            ob = pfe_pkg::cell_at(pfe_pkg::next_mod5(r2), c2);
        end else begin
            oa = pfe_pkg::cell_at(r1, c2);
            ob = pfe_pkg::cell_at(r2, c1);
        end
    end
    assign emit_addr = cmd.emit_b ? ob : oa;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pfe_pkg::CELLS; i++) begin
                key_square_reg[i] <= '0;
            end
            for (int i = 0; i < pfe_pkg::LETTERS; i++) begin
                position_reg[i] <= '0;
            end
            used_reg        <= pfe_pkg::LETTERS'(1) << pfe_pkg::LETTER_J;
            fill_count_reg  <= '0;
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            walk_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (place_ok) begin
                key_square_reg[fill_count_reg] <= place_idx;
                position_reg[place_idx]        <= fill_count_reg;
                used_reg[place_idx]            <= 1'b1;
                fill_count_reg                 <= fill_count_reg + 5'd1;
            end
            if (cmd.fill_start) begin
                walk_reg <= '0;
            end else if (cmd.fill_step) begin
                walk_reg <= walk_reg + 5'd1;
            end
            if (cmd.held_set) begin
                held_letter_reg <= idx_reg;
                held_valid_reg  <= 1'b1;
            end else if (cmd.held_clear) begin
                held_valid_reg  <= 1'b0;
            end
            if (cmd.emit_a || cmd.emit_b) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= pfe_pkg::op_t'(s_op);
            idx_reg       <= in_decoded[4:0];
            is_letter_reg <= in_decoded[5];
        end
        if (cmd.pair_load) begin
            a_reg <= held_letter_reg;
            unique case (cmd.b_sel)
                pfe_pkg::B_X: b_reg <= pfe_pkg::LETTER_X;
                pfe_pkg::B_Z: b_reg <= pfe_pkg::LETTER_Z;
                default:      b_reg <= idx_reg;
            endcase
        end
        if (cmd.pos_a) begin
            pa_reg <= lookup_cell;
        end
        if (cmd.pos_b) begin
            pb_reg <= lookup_cell;
        end
        if (cmd.emit_a || cmd.emit_b) begin
            m_letter_reg <= key_square_reg[emit_addr];
            m_last_reg   <= cmd.emit_b;
        end
    end

    assign status.op         = op_reg;
    assign status.is_letter  = is_letter_reg;
    assign status.held_valid = held_valid_reg;
    assign status.held_match = (held_letter_reg == idx_reg);
    assign status.fill_done  = (walk_reg == pfe_pkg::LAST_LETTER);
    assign status.out_free   = out_free;

    assign m_valid         = m_valid_reg;
    assign m_cipher_letter = m_letter_reg;
    assign m_last          = m_last_reg;

endmodule

`default_nettype wire

FILE: hdl/pfe_ctrl.sv
`default_nettype none

module pfe_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pfe_pkg::status_t  status,
    output pfe_pkg::cmd_t          cmd
);

    pfe_pkg::ctrl_state_t state_reg;
    pfe_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pfe_pkg::ST_DECODE;
                end
            end
            pfe_pkg::ST_DECODE: begin
                unique case (status.op)
                    pfe_pkg::OP_KEY_END: state_next = pfe_pkg::ST_FILL;
                    pfe_pkg::OP_TEXT: begin
                        state_next = (status.is_letter && status.held_valid)
                                     ? pfe_pkg::ST_POS_A : pfe_pkg::ST_IDLE;
                    end
                    pfe_pkg::OP_END: begin
                        state_next = status.held_valid ? pfe_pkg::ST_POS_A
                                                       : pfe_pkg::ST_IDLE;
                    end
                    default: state_next = pfe_pkg::ST_IDLE;
                endcase
            end
            pfe_pkg::ST_FILL: begin
                if (status.fill_done) begin
                    state_next = pfe_pkg::ST_IDLE;
                end
            end
            pfe_pkg::ST_POS_A: state_next = pfe_pkg::ST_POS_B;
            pfe_pkg::ST_POS_B: state_next = pfe_pkg::ST_EMIT_A;
            pfe_pkg::ST_EMIT_A: begin
                if (status.out_free) begin
                    state_next = pfe_pkg::ST_EMIT_B;
                end
            end
            pfe_pkg::ST_EMIT_B: begin
                if (status.out_free) begin
                    state_next = pfe_pkg::ST_IDLE;
                end
            end
            default: state_next = pfe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            pfe_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            pfe_pkg::ST_DECODE: begin
                unique case (status.op)
                    pfe_pkg::OP_KEY: cmd.place_input = status.is_letter;
                    pfe_pkg::OP_KEY_END: cmd.fill_start = 1'b1;
                    pfe_pkg::OP_TEXT: begin
                        if (status.is_letter) begin
                            if (!status.held_valid) begin
                                cmd.held_set = 1'b1;
                            end else begin
                                // An equal pair takes x and keeps the letter held.
                                cmd.pair_load  = 1'b1;
                                cmd.b_sel      = status.held_match ? pfe_pkg::B_X
                                                                   : pfe_pkg::B_INPUT;
                                cmd.held_clear = !status.held_match;
                            end
                        end
                    end
                    default: begin
                        if (status.held_valid) begin
                            cmd.pair_load  = 1'b1;
                            cmd.b_sel      = pfe_pkg::B_Z;
                            cmd.held_clear = 1'b1;
                        end
                    end
                endcase
            end
            pfe_pkg::ST_FILL:   cmd.fill_step = 1'b1;
            pfe_pkg::ST_POS_A:  cmd.pos_a = 1'b1;
            pfe_pkg::ST_POS_B:  cmd.pos_b = 1'b1;
            pfe_pkg::ST_EMIT_A: cmd.emit_a = status.out_free;
            pfe_pkg::ST_EMIT_B: cmd.emit_b = status.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
